### sv/cau_pkg.sv
// Shared types, widths and saturation helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PW = 2 * WORD_BITS;        // product width
  localparam int SW = PW + 1;               // signed sum of two products
  localparam int NW = PW + FRAC_BITS;       // scaled dividend magnitude
  localparam int QB = WORD_BITS + 1;        // quotient bits kept
  localparam int DW = PW + 1;               // divisor (sum of squares)
  localparam int RW = DW + 1;               // partial remainder

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_NEG   = 3'd5,
    OP_RECIP = 3'd6,
    OP_EQ    = 3'd7
  } op_t;

  typedef struct packed {
    op_t                  kind;
    logic                 eq;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [WORD_BITS-1:0] res_re;
    logic [WORD_BITS-1:0] res_im;
    logic [RW-1:0]        rem_re;
    logic [RW-1:0]        rem_im;
    logic [QB-1:0]        nb_re;
    logic [QB-1:0]        nb_im;
    logic [QB-1:0]        q_re;
    logic [QB-1:0]        q_im;
    logic [DW-1:0]        den;
  } pipe_t;

  // clamp a sign and magnitude to the signed word
  function automatic logic [WORD_BITS-1:0] sat_q(input logic neg, input logic ovf,
                                                 input logic [QB-1:0] q);
    logic [QB-1:0] lim;
    logic [QB-1:0] m;
    lim = neg ? (QB'(1) << (WORD_BITS - 1)) : ((QB'(1) << (WORD_BITS - 1)) - QB'(1));
    m = (ovf || (q > lim)) ? lim : q;
    sat_q = neg ? (WORD_BITS'(0) - m[WORD_BITS-1:0]) : m[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_s(input logic signed [WORD_BITS:0] v);
    logic [WORD_BITS:0] mag;
    mag = v[WORD_BITS] ? (~v + 1'b1) : v;
    sat_s = sat_q(v[WORD_BITS], 1'b0, QB'(mag));
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_wide(input logic neg,
                                                    input logic [PW-1:0] mag);
    logic [PW-1:0] sh;
    sh = mag >> FRAC_BITS;
    sat_wide = sat_q(neg, |sh[PW-1:QB], sh[QB-1:0]);
  endfunction

endpackage

### sv/complex_arithmetic_unit.sv
// Top level of the pipelined rectangular complex arithmetic unit.
//
// Requests enter on the in_ channel (in_valid / in_stall) with an operation
// code and two complex operands in signed Q16.16; each request yields exactly
// one result on the out_ channel (out_valid / out_stall): real and imaginary
// parts, an equality flag and a divide-by-zero flag.
// Structure: three front stages (products, sums, dividend scaling), then a
// row of WORD_BITS+1 identical divider cells, each producing one quotient bit
// of both lanes and passing the request to its neighbour, then an output
// register. Every operation takes the same path, so results leave in order.
// Throughput: one request per cycle while the receiver does not stall; the
// divider row is the deepest part. Each stage advances whenever its
// successor has room, so bubbles are squeezed out and a new request is
// taken while a finished result waits.
// When the receiver stalls, the output holds and the pipeline fills up;
// in_stall rises only once the first stage cannot hand on its request.
// Reset (rst_n low, synchronous) empties every stage; no request is lost
// or invented afterwards.
module complex_arithmetic_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_kind,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_im,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_im,
  output logic                                 out_are_equal,
  output logic                                 out_div_by_zero
);

  localparam int NC = cau_pkg::QB;

  // link i feeds cell i; link NC feeds the output stage
  logic           lv   [NC+1];
  logic           lrdy [NC+1];
  cau_pkg::pipe_t ld   [NC+1];
  logic           front_rdy;

  assign in_stall = !front_rdy;

  cau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (in_valid),
    .in_rdy  (front_rdy),
    .in_kind (in_kind),
    .in_a_re (in_a_re),
    .in_a_im (in_a_im),
    .in_b_re (in_b_re),
    .in_b_im (in_b_im),
    .out_v   (lv[0]),
    .out_d   (ld[0]),
    .out_rdy (lrdy[0])
  );

  // divider row: one quotient bit per cell, most significant first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (lv[i]),
      .in_rdy  (lrdy[i]),
      .in_d    (ld[i]),
      .out_v   (lv[i+1]),
      .out_d   (ld[i+1]),
      .out_rdy (lrdy[i+1])
    );
  end

  cau_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_v            (lv[NC]),
    .in_rdy          (lrdy[NC]),
    .in_d            (ld[NC]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res_re      (out_res_re),
    .out_res_im      (out_res_im),
    .out_are_equal   (out_are_equal),
    .out_div_by_zero (out_div_by_zero)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> (out_res_re == '0) && (out_res_im == '0))
    else $error("divide by zero with non-zero result");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_are_equal && out_div_by_zero))
    else $error("equality and divide-by-zero flags both set");
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    lv[NC] && !lrdy[NC] |=> lv[NC])
    else $error("last divider cell dropped a request under stall");

endmodule

### sv/cau_front.sv
// Front end: products, sums and dividend preparation over three stages.
module cau_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_v,
  output logic                                  in_rdy,
  input  logic [2:0]                            in_kind,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  in_b_im,
  output logic                                  out_v,
  output cau_pkg::pipe_t                        out_d,
  input  logic                                  out_rdy
);

  localparam int W = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PW;
  localparam int SW = cau_pkg::SW;
  localparam int NW = cau_pkg::NW;
  localparam int QB = cau_pkg::QB;
  localparam int DW = cau_pkg::DW;
  localparam int RW = cau_pkg::RW;

  // stage 1: products
  logic                   v1_r;
  cau_pkg::op_t           k1_r, k1_nxt;
  logic signed [W-1:0]    ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [PW-1:0]   p_r [6];
  logic signed [PW-1:0]   p_nxt [6];
  logic signed [W-1:0]    sx, sy;

  // stage 2: sums and simple results
  logic                   v2_r;
  cau_pkg::op_t           k2_r;
  logic [W-1:0]           re2_r, im2_r, re2_nxt, im2_nxt;
  logic                   eq2_r, eq2_nxt;
  logic signed [SW-1:0]   nr2_r, ni2_r, nr2_nxt, ni2_nxt;
  logic [DW-1:0]          den2_r, den2_nxt;
  logic signed [W:0]      ear, eai, ebr, ebi;
  logic signed [SW-1:0]   q0, q1, q2, q3;

  // stage 3: dividend magnitude and first remainder
  logic                   v3_r;
  cau_pkg::pipe_t         d3_r, d3_nxt;
  logic [SW-1:0]          mr, mi;
  logic [NW-1:0]          nre, nim;
  logic                   is_div;

  logic rdy1, rdy2, rdy3;

  assign rdy3   = !v3_r || out_rdy;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign in_rdy = rdy1;
  assign out_v  = v3_r;
  assign out_d  = d3_r;

  always_comb begin
    k1_nxt   = cau_pkg::op_t'(in_kind);
    sx       = (k1_nxt == cau_pkg::OP_RECIP) ? in_a_re : in_b_re;
    sy       = (k1_nxt == cau_pkg::OP_RECIP) ? in_a_im : in_b_im;
    p_nxt[0] = PW'(in_a_re) * PW'(in_b_re);
    p_nxt[1] = PW'(in_a_im) * PW'(in_b_im);
    p_nxt[2] = PW'(in_a_re) * PW'(in_b_im);
    p_nxt[3] = PW'(in_a_im) * PW'(in_b_re);
    p_nxt[4] = PW'(sx) * PW'(sx);
    p_nxt[5] = PW'(sy) * PW'(sy);
  end

  always_comb begin
    ear = ar1_r;
    eai = ai1_r;
    ebr = br1_r;
    ebi = bi1_r;
    q0  = p_r[0];
    q1  = p_r[1];
    q2  = p_r[2];
    q3  = p_r[3];
    re2_nxt  = '0;
    im2_nxt  = '0;
    eq2_nxt  = 1'b0;
    nr2_nxt  = '0;
    ni2_nxt  = '0;
    den2_nxt = DW'(p_r[4]) + DW'(p_r[5]);
    case (k1_r)
      cau_pkg::OP_ADD: begin
        re2_nxt = cau_pkg::sat_s(ear + ebr);
        im2_nxt = cau_pkg::sat_s(eai + ebi);
      end
      cau_pkg::OP_SUB: begin
        re2_nxt = cau_pkg::sat_s(ear - ebr);
        im2_nxt = cau_pkg::sat_s(eai - ebi);
      end
      cau_pkg::OP_MUL: begin
        nr2_nxt = q0 - q1;
        ni2_nxt = q2 + q3;
      end
      cau_pkg::OP_DIV: begin
        nr2_nxt = q0 + q1;
        ni2_nxt = q3 - q2;
      end
      cau_pkg::OP_CONJ: begin
        re2_nxt = cau_pkg::sat_s(ear);
        im2_nxt = cau_pkg::sat_s(-eai);
      end
      cau_pkg::OP_NEG: begin
        re2_nxt = cau_pkg::sat_s(-ear);
        im2_nxt = cau_pkg::sat_s(-eai);
      end
      cau_pkg::OP_RECIP: begin
        nr2_nxt = SW'(ear);
        ni2_nxt = -SW'(eai);
      end
      default: begin
        eq2_nxt = (ar1_r == br1_r) && (ai1_r == bi1_r);
      end
    endcase
  end

  always_comb begin
    mr     = nr2_r[SW-1] ? (~nr2_r + 1'b1) : nr2_r;
    mi     = ni2_r[SW-1] ? (~ni2_r + 1'b1) : ni2_r;
    is_div = (k2_r == cau_pkg::OP_DIV) || (k2_r == cau_pkg::OP_RECIP);
    if (k2_r == cau_pkg::OP_RECIP) begin
      nre = NW'(mr[PW-1:0]) << (2 * cau_pkg::FRAC_BITS);
      nim = NW'(mi[PW-1:0]) << (2 * cau_pkg::FRAC_BITS);
    end else begin
      nre = NW'(mr[PW-1:0]) << cau_pkg::FRAC_BITS;
      nim = NW'(mi[PW-1:0]) << cau_pkg::FRAC_BITS;
    end
    d3_nxt.kind   = k2_r;
    d3_nxt.eq     = eq2_r;
    d3_nxt.dz     = is_div && (den2_r == '0);
    d3_nxt.neg_re = nr2_r[SW-1];
    d3_nxt.neg_im = ni2_r[SW-1];
    d3_nxt.ovf_re = (nre >> QB) >= NW'(den2_r);
    d3_nxt.ovf_im = (nim >> QB) >= NW'(den2_r);
    d3_nxt.res_re = re2_r;
    d3_nxt.res_im = im2_r;
    if (k2_r == cau_pkg::OP_MUL) begin
      d3_nxt.res_re = cau_pkg::sat_wide(nr2_r[SW-1], mr[PW-1:0]);
      d3_nxt.res_im = cau_pkg::sat_wide(ni2_r[SW-1], mi[PW-1:0]);
    end
    d3_nxt.rem_re = RW'(nre >> QB);
    d3_nxt.rem_im = RW'(nim >> QB);
    d3_nxt.nb_re  = nre[QB-1:0];
    d3_nxt.nb_im  = nim[QB-1:0];
    d3_nxt.q_re   = '0;
    d3_nxt.q_im   = '0;
    d3_nxt.den    = den2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_v;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      k1_r  <= k1_nxt;
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
    end
    if (rdy2) begin
      k2_r   <= k1_r;
      re2_r  <= re2_nxt;
      im2_r  <= im2_nxt;
      eq2_r  <= eq2_nxt;
      nr2_r  <= nr2_nxt;
      ni2_r  <= ni2_nxt;
      den2_r <= den2_nxt;
    end
    if (rdy3) d3_r <= d3_nxt;
  end

endmodule

### sv/cau_cell.sv
// One restoring divider cell: one quotient bit for each lane per request.
module cau_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_v,
  output logic           in_rdy,
  input  cau_pkg::pipe_t in_d,
  output logic           out_v,
  output cau_pkg::pipe_t out_d,
  input  logic           out_rdy
);

  localparam int RW = cau_pkg::RW;
  localparam int QB = cau_pkg::QB;

  logic           v_r;
  cau_pkg::pipe_t d_r, d_nxt;
  logic [RW-1:0]  tr, ti, dd;

  assign in_rdy = !v_r || out_rdy;
  assign out_v  = v_r;
  assign out_d  = d_r;

  always_comb begin
    d_nxt = in_d;
    dd    = RW'(in_d.den);
    tr    = {in_d.rem_re[RW-2:0], in_d.nb_re[QB-1]};
    ti    = {in_d.rem_im[RW-2:0], in_d.nb_im[QB-1]};
    d_nxt.nb_re  = in_d.nb_re << 1;
    d_nxt.nb_im  = in_d.nb_im << 1;
    d_nxt.rem_re = (tr >= dd) ? (tr - dd) : tr;
    d_nxt.rem_im = (ti >= dd) ? (ti - dd) : ti;
    d_nxt.q_re   = {in_d.q_re[QB-2:0], tr >= dd};
    d_nxt.q_im   = {in_d.q_im[QB-2:0], ti >= dd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) d_r <= d_nxt;
  end

  // a held request keeps its quotient while the neighbour is full
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_rdy |=> v_r && $stable(d_r.q_re) && $stable(d_r.q_im))
    else $error("cell lost a held request");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_v && in_rdy |=> v_r)
    else $error("cell dropped an incoming request");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !d_r.ovf_re && (d_r.den != '0) && (d_r.kind == cau_pkg::OP_DIV)
    |-> d_r.rem_re < RW'(d_r.den))
    else $error("partial remainder not below divisor");

endmodule

### sv/cau_back.sv
// Back end: quotient saturation, result selection and output register.
module cau_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  output logic                          in_rdy,
  input  cau_pkg::pipe_t                in_d,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cau_pkg::WORD_BITS-1:0] out_res_re,
  output logic [cau_pkg::WORD_BITS-1:0] out_res_im,
  output logic                          out_are_equal,
  output logic                          out_div_by_zero
);

  localparam int W = cau_pkg::WORD_BITS;

  logic         v_r;
  logic [W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic         eq_r, dz_r;

  assign in_rdy          = !v_r || !out_stall;
  assign out_valid       = v_r;
  assign out_res_re      = re_r;
  assign out_res_im      = im_r;
  assign out_are_equal   = eq_r;
  assign out_div_by_zero = dz_r;

  always_comb begin
    re_nxt = in_d.res_re;
    im_nxt = in_d.res_im;
    if ((in_d.kind == cau_pkg::OP_DIV) || (in_d.kind == cau_pkg::OP_RECIP)) begin
      if (in_d.dz) begin
        re_nxt = '0;
        im_nxt = '0;
      end else begin
        re_nxt = cau_pkg::sat_q(in_d.neg_re, in_d.ovf_re, in_d.q_re);
        im_nxt = cau_pkg::sat_q(in_d.neg_im, in_d.ovf_im, in_d.q_im);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      eq_r <= in_d.eq;
      dz_r <= in_d.dz;
    end
  end

endmodule

### bench/cau_scoreboard.sv
// Result predictor and scoreboard for the complex arithmetic unit.
module cau_scoreboard (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [2:0]                           in_kind,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_im,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [cau_pkg::WORD_BITS-1:0] out_res_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] out_res_im,
  input  logic                                 out_are_equal,
  input  logic                                 out_div_by_zero,
  output int                                   mismatches,
  output int                                   pending
);

  localparam int WORD_BITS = cau_pkg::WORD_BITS;
  localparam int FRAC_BITS = cau_pkg::FRAC_BITS;

  typedef logic signed [127:0] wide_t;
  typedef logic [127:0] uwide_t;

  typedef struct {
    logic [WORD_BITS-1:0] re;
    logic [WORD_BITS-1:0] im;
    logic                 eq;
    logic                 dz;
  } cplx_result_t;

  cplx_result_t awaited_results[$];

  function automatic logic [WORD_BITS-1:0] clamp_word(input logic neg, input uwide_t mag);
    uwide_t lim;
    uwide_t m;
    lim = neg ? (uwide_t'(1) << (WORD_BITS - 1)) : ((uwide_t'(1) << (WORD_BITS - 1)) - 1);
    m = (mag > lim) ? lim : mag;
    return neg ? WORD_BITS'(-m) : WORD_BITS'(m);
  endfunction

  function automatic uwide_t magnitude(input wide_t v);
    return (v < 0) ? uwide_t'(-v) : uwide_t'(v);
  endfunction

  function automatic logic [WORD_BITS-1:0] clamp_signed(input wide_t v);
    return clamp_word(v < 0, magnitude(v));
  endfunction

  function automatic logic [WORD_BITS-1:0] rescale(input wide_t v);
    return clamp_word(v < 0, magnitude(v) >> FRAC_BITS);
  endfunction

  // num * 2^shift / den, truncated toward zero
  function automatic logic [WORD_BITS-1:0] scaled_quotient(input wide_t num, input int shift,
                                                           input uwide_t den);
    uwide_t q;
    q = (magnitude(num) << shift) / den;
    return clamp_word((num < 0) && (q != 0), q);
  endfunction

  function automatic cplx_result_t compute_complex(input cau_pkg::op_t kind, input wide_t ar,
                                                   input wide_t ai, input wide_t br,
                                                   input wide_t bi);
    cplx_result_t r;
    uwide_t den;
    r = '{re: '0, im: '0, eq: 1'b0, dz: 1'b0};
    case (kind)
      cau_pkg::OP_ADD: begin
        r.re = clamp_signed(ar + br);
        r.im = clamp_signed(ai + bi);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp_signed(ar - br);
        r.im = clamp_signed(ai - bi);
      end
      cau_pkg::OP_MUL: begin
        r.re = rescale(ar * br - ai * bi);
        r.im = rescale(ar * bi + ai * br);
      end
      cau_pkg::OP_DIV: begin
        den = uwide_t'(br * br + bi * bi);
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = scaled_quotient(ar * br + ai * bi, FRAC_BITS, den);
          r.im = scaled_quotient(ai * br - ar * bi, FRAC_BITS, den);
        end
      end
      cau_pkg::OP_CONJ: begin
        r.re = clamp_signed(ar);
        r.im = clamp_signed(-ai);
      end
      cau_pkg::OP_NEG: begin
        r.re = clamp_signed(-ar);
        r.im = clamp_signed(-ai);
      end
      cau_pkg::OP_RECIP: begin
        den = uwide_t'(ar * ar + ai * ai);
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = scaled_quotient(ar, 2 * FRAC_BITS, den);
          r.im = scaled_quotient(-ai, 2 * FRAC_BITS, den);
        end
      end
      default: r.eq = (ar == br) && (ai == bi);
    endcase
    return r;
  endfunction

  assign pending = awaited_results.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    cplx_result_t want;
    if (rst_n && in_valid && !in_stall)
      awaited_results.push_back(compute_complex(cau_pkg::op_t'(in_kind), wide_t'(in_a_re),
                                                wide_t'(in_a_im), wide_t'(in_b_re),
                                                wide_t'(in_b_im)));
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%h im=%h", out_res_re, out_res_im);
      end else begin
        want = awaited_results.pop_front();
        if (out_res_re !== want.re || out_res_im !== want.im ||
            out_are_equal !== want.eq || out_div_by_zero !== want.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want re=%h im=%h eq=%b dz=%b, got re=%h im=%h eq=%b dz=%b",
                     want.re, want.im, want.eq, want.dz,
                     out_res_re, out_res_im, out_are_equal, out_div_by_zero);
        end
      end
    end
  end

endmodule

### bench/tb.sv
// Stimulus, idling and verdict for the complex arithmetic unit testbench.
module tb;

  localparam int WORD_BITS = cau_pkg::WORD_BITS;
  localparam int FRAC_BITS = cau_pkg::FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] ONE  = 1 <<< FRAC_BITS;
  localparam int RANDOM_REQUESTS = 1530;
  localparam int STALL_LIMIT     = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_kind;
  logic signed [WORD_BITS-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  logic out_stall;
  logic signed [WORD_BITS-1:0] out_res_re, out_res_im;
  logic out_are_equal, out_div_by_zero;
  int mismatches;
  int pending;
  bit calm;      // when set, neither side idles
  int quiet_cycles;

  complex_arithmetic_unit dut (.*);

  cau_scoreboard scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset with every input at a known value.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = cau_pkg::OP_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b0;
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Draw an idle count; none while the calm stretch lasts.
  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Pick an operand part: full range, small, extremes, plus or minus one, or zero.
  function automatic logic signed [WORD_BITS-1:0] operand_draw();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      5:       return $urandom_range(0, 1) ? WMAX : WMIN;
      6:       return $urandom_range(0, 1) ? ONE : -ONE;
      default: return '0;
    endcase
  endfunction

  // Offer one request after an idle gap and hold it until it is taken.
  task automatic send_request(input cau_pkg::op_t kind,
                              input logic signed [WORD_BITS-1:0] ar,
                              input logic signed [WORD_BITS-1:0] ai,
                              input logic signed [WORD_BITS-1:0] br,
                              input logic signed [WORD_BITS-1:0] bi);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    do @(posedge clk); while (in_stall);
  endtask

  // Receiver: stall for a drawn number of cycles before taking each result.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    cau_pkg::op_t kind;
    logic signed [WORD_BITS-1:0] ar, ai, br, bi;
    @(posedge rst_n);

    // Directed: extremes, every operation, zero divisors, negated minimum.
    send_request(cau_pkg::OP_ADD, WMAX, WMIN, WMAX, WMIN);
    send_request(cau_pkg::OP_SUB, WMIN, WMAX, WMAX, WMIN);
    send_request(cau_pkg::OP_MUL, WMAX, WMAX, WMAX, WMIN);
    send_request(cau_pkg::OP_MUL, WMIN, WMIN, WMIN, WMIN);
    send_request(cau_pkg::OP_MUL, ONE, -ONE, 3, -5);
    send_request(cau_pkg::OP_DIV, ONE, ONE, '0, '0);
    send_request(cau_pkg::OP_DIV, WMAX, WMIN, 1, 0);
    send_request(cau_pkg::OP_DIV, WMIN, WMIN, WMIN, WMIN);
    send_request(cau_pkg::OP_DIV, -3, 7, ONE, ONE);
    send_request(cau_pkg::OP_CONJ, WMIN, WMIN, '0, '0);
    send_request(cau_pkg::OP_CONJ, WMAX, WMAX, '0, '0);
    send_request(cau_pkg::OP_NEG, WMIN, WMIN, '0, '0);
    send_request(cau_pkg::OP_NEG, WMAX, -1, '0, '0);
    send_request(cau_pkg::OP_RECIP, '0, '0, ONE, ONE);
    send_request(cau_pkg::OP_RECIP, 1, 0, '0, '0);
    send_request(cau_pkg::OP_RECIP, WMIN, WMIN, '0, '0);
    send_request(cau_pkg::OP_RECIP, -ONE, ONE, '0, '0);
    send_request(cau_pkg::OP_EQ, WMIN, WMAX, WMIN, WMAX);
    send_request(cau_pkg::OP_EQ, WMIN, WMAX, WMIN, WMAX - 1);
    send_request(cau_pkg::OP_EQ, '0, '0, '0, '0);

    // Let every result drain before the random part.
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = cau_pkg::op_t'($urandom_range(0, 7));
      ar = operand_draw();
      ai = operand_draw();
      br = operand_draw();
      bi = operand_draw();
      // Make the equality test hit often.
      if (kind == cau_pkg::OP_EQ && $urandom_range(0, 1)) begin
        br = ar;
        bi = ai;
      end
      send_request(kind, ar, ai, br, bi);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

### files.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_cell.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
bench/cau_scoreboard.sv
bench/tb.sv
